// ===== hw/rtl/tarhv_pkg.sv =====
// ----------------------------------------------------------------------------
// tarhv_pkg
// Shared types, constants and helper functions for the tar header validator.
// ----------------------------------------------------------------------------
`default_nettype none

package tarhv_pkg;

    localparam int HEADER_BYTES = 500;
    localparam int BLOCK_BYTES  = 512;

    localparam int BYTE_W   = 8;
    localparam int OFF_W    = 48;
    localparam int SIZE_W   = 36;
    localparam int CSUM_W   = 24;
    localparam int SUM_W    = 17;
    localparam int IDX_W    = $clog2(HEADER_BYTES);
    localparam int BLK_SH   = $clog2(BLOCK_BYTES);
    localparam int BLKCNT_W = SIZE_W - BLK_SH + 1;

    localparam int S_TDATA_W = ((BYTE_W + OFF_W + 7) / 8) * 8;
    localparam int M_DATA_BITS = SIZE_W + 2 * OFF_W;
    localparam int M_TDATA_W = ((M_DATA_BITS + 7) / 8) * 8;
    localparam int M_TUSER_W = 2;

    localparam logic [IDX_W-1:0] SIZE_FIRST  = IDX_W'(124);
    localparam logic [IDX_W-1:0] SIZE_LAST   = IDX_W'(135);
    localparam logic [IDX_W-1:0] CSUM_FIRST  = IDX_W'(148);
    localparam logic [IDX_W-1:0] CSUM_LAST   = IDX_W'(155);
    localparam logic [IDX_W-1:0] MAGIC_FIRST = IDX_W'(257);
    localparam logic [IDX_W-1:0] MAGIC_LAST  = IDX_W'(264);
    localparam logic [IDX_W-1:0] LAST_INDEX  = IDX_W'(HEADER_BYTES - 1);

    localparam logic [BYTE_W-1:0] SPACE_BYTE = 8'h20;
    localparam logic [BYTE_W-1:0] DIGIT_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] DIGIT_SEVEN = 8'h37;

    // Magic text "ustar  " plus NUL; byte k sits at bits [8k +: 8].
    localparam logic [63:0] MAGIC_TEXT = {8'h00, 8'h20, 8'h20, 8'h72,
                                          8'h61, 8'h74, 8'h73, 8'h75};

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_DIGITS,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic [SIZE_W-1:0] value;
        t_phase            phase;
    } t_octal;

    // Per-header summary handed from the accumulator to the top level.
    typedef struct packed {
        logic              last;
        logic              valid;
        logic [SIZE_W-1:0] size;
    } t_hdr_status;

    // One step of the octal field parser: skip leading spaces, then take
    // digits until the first byte that is not an octal digit.
    function automatic t_octal octal_step(t_octal cur, logic [BYTE_W-1:0] b);
        t_octal nxt;
        logic   digit;
        nxt   = cur;
        digit = (b >= DIGIT_ZERO) && (b <= DIGIT_SEVEN);
        unique case (cur.phase)
            PH_SKIP: begin
                if (b != SPACE_BYTE) begin
                    if (digit) begin
                        nxt.value = {{(SIZE_W-3){1'b0}}, b[2:0]};
                        nxt.phase = PH_DIGITS;
                    end else begin
                        nxt.phase = PH_DONE;
                    end
                end
            end
            PH_DIGITS: begin
                if (digit) begin
                    nxt.value = {cur.value[SIZE_W-4:0], b[2:0]};
                end else begin
                    nxt.phase = PH_DONE;
                end
            end
            default: begin
                nxt = cur;
            end
        endcase
        return nxt;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tarhv_accum.sv =====
// ----------------------------------------------------------------------------
// tarhv_accum
// Per-header running state: byte index, byte sum, octal parsers, magic check.
// ----------------------------------------------------------------------------
`default_nettype none

module tarhv_accum (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_step,
    input  wire logic [tarhv_pkg::BYTE_W-1:0] i_byte,
    input  wire logic                       i_start,
    output tarhv_pkg::t_hdr_status          o_status
);
    import tarhv_pkg::*;

    logic [IDX_W-1:0]  r_index, n_index;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [CSUM_W-1:0] r_csum, n_csum;
    t_phase            r_csum_ph, n_csum_ph;
    logic [SIZE_W-1:0] r_size, n_size;
    t_phase            r_size_ph, n_size_ph;
    logic              r_magic, n_magic;

    logic [IDX_W-1:0]  base_idx;
    logic [SUM_W-1:0]  base_sum;
    logic              base_magic;
    t_octal            csum_cur, csum_nxt, size_cur, size_nxt;
    logic              in_csum, in_size, in_magic;
    logic [IDX_W-1:0]  magic_off;
    logic [BYTE_W-1:0] magic_exp;
    logic              is_last;

    // A start flag drops any partial header: work from reset values.
    always_comb begin
        base_idx   = i_start ? '0 : r_index;
        base_sum   = i_start ? '0 : r_sum;
        base_magic = i_start ? 1'b1 : r_magic;
        csum_cur.value = i_start ? '0 : {{(SIZE_W-CSUM_W){1'b0}}, r_csum};
        csum_cur.phase = i_start ? PH_SKIP : r_csum_ph;
        size_cur.value = i_start ? '0 : r_size;
        size_cur.phase = i_start ? PH_SKIP : r_size_ph;

        in_csum  = (base_idx >= CSUM_FIRST) && (base_idx <= CSUM_LAST);
        in_size  = (base_idx >= SIZE_FIRST) && (base_idx <= SIZE_LAST);
        in_magic = (base_idx >= MAGIC_FIRST) && (base_idx <= MAGIC_LAST);
        magic_off = base_idx - MAGIC_FIRST;
        magic_exp = MAGIC_TEXT[{magic_off[2:0], 3'b000} +: BYTE_W];

        csum_nxt = octal_step(csum_cur, i_byte);
        size_nxt = octal_step(size_cur, i_byte);

        // Checksum bytes count as spaces in the sum.
        n_sum = base_sum + {{(SUM_W-BYTE_W){1'b0}}, (in_csum ? SPACE_BYTE : i_byte)};
        n_csum    = in_csum ? csum_nxt.value[CSUM_W-1:0] : csum_cur.value[CSUM_W-1:0];
        n_csum_ph = in_csum ? csum_nxt.phase : csum_cur.phase;
        n_size    = in_size ? size_nxt.value : size_cur.value;
        n_size_ph = in_size ? size_nxt.phase : size_cur.phase;
        n_magic   = base_magic & ~(in_magic && (i_byte != magic_exp));
        n_index   = base_idx + IDX_W'(1);
        is_last   = (base_idx >= LAST_INDEX);
    end

    always_comb begin
        o_status.last  = is_last;
        o_status.valid = n_magic && (n_csum == {{(CSUM_W-SUM_W){1'b0}}, n_sum});
        o_status.size  = n_size;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index   <= '0;
            r_sum     <= '0;
            r_csum    <= '0;
            r_csum_ph <= PH_SKIP;
            r_size    <= '0;
            r_size_ph <= PH_SKIP;
            r_magic   <= 1'b1;
        end else if (i_step) begin
            if (is_last) begin
                r_index   <= '0;
                r_sum     <= '0;
                r_csum    <= '0;
                r_csum_ph <= PH_SKIP;
                r_size    <= '0;
                r_size_ph <= PH_SKIP;
                r_magic   <= 1'b1;
            end else begin
                r_index   <= n_index;
                r_sum     <= n_sum;
                r_csum    <= n_csum;
                r_csum_ph <= n_csum_ph;
                r_size    <= n_size;
                r_size_ph <= n_size_ph;
                r_magic   <= n_magic;
            end
        end
    end

`ifndef SYNTH
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_index <= LAST_INDEX)
        else $error("byte index ran past the last header byte");

    a_wrap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && is_last) |=> (r_index == '0) && r_magic && (r_sum == '0))
        else $error("state not cleared after the last header byte");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/tarhv_offset.sv =====
// ----------------------------------------------------------------------------
// tarhv_offset
// Data offset and next header offset from the header offset and file size.
// ----------------------------------------------------------------------------
`default_nettype none

module tarhv_offset (
    input  wire logic [tarhv_pkg::OFF_W-1:0]  i_hdr_off,
    input  wire logic [tarhv_pkg::SIZE_W-1:0] i_size,
    output logic      [tarhv_pkg::OFF_W-1:0]  o_data_off,
    output logic      [tarhv_pkg::OFF_W-1:0]  o_next_off,
    output logic                              o_ovf
);
    import tarhv_pkg::*;

    logic [BLKCNT_W-1:0] blk_p1;
    logic [OFF_W:0]      data_sum;
    logic [OFF_W:0]      next_sum;

    // Rounded-up block count plus the header block itself.
    always_comb begin
        blk_p1 = {1'b0, i_size[SIZE_W-1:BLK_SH]} + BLKCNT_W'(1)
               + {{(BLKCNT_W-1){1'b0}}, |i_size[BLK_SH-1:0]};
        data_sum = {1'b0, i_hdr_off} + (OFF_W+1)'(BLOCK_BYTES);
        next_sum = {1'b0, i_hdr_off}
                 + {{(OFF_W+1-BLKCNT_W-BLK_SH){1'b0}}, blk_p1, {BLK_SH{1'b0}}};
        o_data_off = data_sum[OFF_W-1:0];
        o_next_off = next_sum[OFF_W-1:0];
        o_ovf      = data_sum[OFF_W] | next_sum[OFF_W];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tar_header_validator.sv =====
// ----------------------------------------------------------------------------
// tar_header_validator
// Streams a tar header byte by byte and reports checksum/magic validity,
// file size and the offsets of the file data and of the next header.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Payload
//   s_axis    in         tdata: byte_value[7:0], hdr_off[55:8]
//                        tuser: start_flag[0]
//   m_axis    out        tdata: entry_size[35:0], data_offset[83:36],
//                               next_hdr_off[131:84], zero pad
//                        tuser: header_valid[0], offset_overflow[1]
//
// Each byte lands in the input register, and the running state is updated from
// it as it moves on. A new byte is taken every cycle unless the input is held
// up as below. The last header byte also loads the result register as it
// moves on from the input register.
// Reset is synchronous and active low; after it the next byte is header byte 0.
// A stalled result only holds up the input when the next last byte needs the
// result register; all other bytes keep flowing.
// ----------------------------------------------------------------------------
`default_nettype none

module tar_header_validator (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // byte_value [7:0], hdr_off [55:8]
    input  wire logic [tarhv_pkg::S_TDATA_W-1:0]     i_s_axis_tdata,
    // start_flag [0]
    input  wire logic                                i_s_axis_tuser,
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    // entry_size [35:0], data_offset [83:36], next_hdr_off [131:84]
    output logic      [tarhv_pkg::M_TDATA_W-1:0]     o_m_axis_tdata,
    // header_valid [0], offset_overflow [1]
    output logic      [tarhv_pkg::M_TUSER_W-1:0]     o_m_axis_tuser
);
    import tarhv_pkg::*;

    // Input register.
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_start;
    logic [OFF_W-1:0]  r_in_off;

    // Result register.
    logic              r_out_valid;
    logic              r_hdr_valid;
    logic [SIZE_W-1:0] r_fsize;
    logic [OFF_W-1:0]  r_doff;
    logic [OFF_W-1:0]  r_noff;
    logic              r_ovf;

    t_hdr_status       status;
    logic [OFF_W-1:0]  data_off;
    logic [OFF_W-1:0]  next_off;
    logic              ovf;
    logic              advance;
    logic              in_xfer;

    // The byte in the input register moves on unless it finishes a header
    // and the result register is still holding an untaken result.
    assign advance = r_in_valid && (!status.last || !r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_xfer = i_s_axis_tvalid && o_s_axis_tready;

    tarhv_accum u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_byte   (r_in_byte),
        .i_start  (r_in_start),
        .o_status (status)
    );

    tarhv_offset u_offset (
        .i_hdr_off  (r_in_off),
        .i_size     (status.size),
        .o_data_off (data_off),
        .o_next_off (next_off),
        .o_ovf      (ovf)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_byte  <= i_s_axis_tdata[BYTE_W-1:0];
            r_in_off   <= i_s_axis_tdata[BYTE_W +: OFF_W];
            r_in_start <= i_s_axis_tuser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && status.last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // An invalid header reports all zeros.
    always_ff @(posedge i_clk) begin
        if (advance && status.last) begin
            r_hdr_valid <= status.valid;
            r_fsize     <= status.valid ? status.size : '0;
            r_doff      <= status.valid ? data_off : '0;
            r_noff      <= status.valid ? next_off : '0;
            r_ovf       <= status.valid & ovf;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(M_TDATA_W-M_DATA_BITS){1'b0}}, r_noff, r_doff, r_fsize};
    assign o_m_axis_tuser  = {r_ovf, r_hdr_valid};

`ifndef SYNTH
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_hdr_valid) |->
            (r_fsize == '0) && (r_doff == '0) && (r_noff == '0) && !r_ovf)
        else $error("invalid header result carries nonzero fields");

    a_last_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && status.last && r_out_valid && !i_m_axis_tready) |=>
            (r_in_valid && $stable(r_in_byte) && $stable(r_in_off)))
        else $error("last header byte left the input register during a stall");
`endif

endmodule

`default_nettype wire
